@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)

`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

@@ sv/wspfp_pkg.sv @@
// ----------------------------------------------------------------------------
// WebSocket pixel frame parser package
// Parse phases, opcodes, header constants and the event record.
// ----------------------------------------------------------------------------
package wspfp_pkg;

    typedef enum logic [2:0] {
        PH_B0,
        PH_B1,
        PH_EXT,
        PH_KEY,
        PH_PAY
    } phase_t;

    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_BINARY = 4'h2;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    localparam logic EV_PIXEL = 1'b0;
    localparam logic EV_CLOSE = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] color;
    } event_t;

endpackage

@@ sv/wspfp_frame_parser.sv @@
// ----------------------------------------------------------------------------
// Frame parser
// Input byte register and the header/payload state machine; one byte a cycle while the event queue is not full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wspfp_frame_parser
    import wspfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       q_full,
    output logic       evt_vld,
    output event_t     evt
);

    logic        in_vld_reg;
    logic [7:0]  byte_reg;
    logic        step;

    phase_t      phase_reg, phase_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        final_reg, final_next;
    logic        masked_reg, masked_next;
    logic [63:0] len_reg, len_next;
    logic [1:0]  idx_reg, idx_next;
    logic [31:0] key_reg, key_next;
    logic [1:0]  grp_reg, grp_next;
    logic [7:0]  held_x_reg, held_x_next;
    logic [7:0]  held_y_reg, held_y_next;

    logic        len_known;
    logic        known_masked;
    logic        hdr_done;
    logic        frame_end;
    logic [63:0] known_len;
    logic [63:0] ext_len;
    logic [31:0] ext_key;
    logic [3:0]  cnt_dec;
    logic [7:0]  key_byte;
    logic [7:0]  plain;
    logic [6:0]  len7;

    assign in_stall = in_vld_reg && q_full;
    assign step     = in_vld_reg && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            byte_reg <= in_byte;
        end
    end

    always_comb
    begin
        case (idx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    assign plain   = byte_reg ^ key_byte;
    assign len7    = byte_reg[6:0];
    assign ext_len = {len_reg[55:0], byte_reg};
    assign ext_key = {key_reg[23:0], byte_reg};
    assign cnt_dec = (cnt_reg != 4'd0) ? cnt_reg - 4'd1 : cnt_reg;

    always_comb
    begin
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        opcode_next  = opcode_reg;
        final_next   = final_reg;
        masked_next  = masked_reg;
        len_next     = len_reg;
        idx_next     = idx_reg;
        key_next     = key_reg;
        grp_next     = grp_reg;
        held_x_next  = held_x_reg;
        held_y_next  = held_y_reg;
        len_known    = 1'b0;
        known_masked = masked_reg;
        known_len    = len_reg;
        hdr_done     = 1'b0;
        frame_end    = 1'b0;
        evt_vld      = 1'b0;
        evt          = '0;

        case (phase_reg)
            PH_B1:
            begin
                masked_next  = byte_reg[7];
                known_masked = byte_reg[7];
                key_next     = '0;
                if (len7 == LEN7_EXT16)
                begin
                    len_next   = '0;
                    cnt_next   = EXT16_BYTES;
                    phase_next = PH_EXT;
                end
                else if (len7 == LEN7_EXT64)
                begin
                    len_next   = '0;
                    cnt_next   = EXT64_BYTES;
                    phase_next = PH_EXT;
                end
                else
                begin
                    len_next  = {57'd0, len7};
                    known_len = {57'd0, len7};
                    len_known = 1'b1;
                end
            end
            PH_EXT:
            begin
                len_next  = ext_len;
                known_len = ext_len;
                cnt_next  = cnt_dec;
                len_known = (cnt_dec == 4'd0);
            end
            PH_KEY:
            begin
                key_next = ext_key;
                cnt_next = cnt_dec;
                hdr_done = (cnt_dec == 4'd0);
            end
            PH_PAY:
            begin
                case (grp_reg)
                    2'd0:
                    begin
                        held_x_next = plain;
                        grp_next    = 2'd1;
                    end
                    2'd1:
                    begin
                        held_y_next = plain;
                        grp_next    = 2'd2;
                    end
                    default:
                    begin
                        evt_vld   = final_reg && (opcode_reg == OP_BINARY);
                        evt.kind  = EV_PIXEL;
                        evt.x     = held_x_reg;
                        evt.y     = held_y_reg;
                        evt.color = plain;
                        grp_next  = 2'd0;
                    end
                endcase
                idx_next  = idx_reg + 2'd1;
                len_next  = len_reg - 64'd1;
                frame_end = (len_reg == 64'd1);
            end
            default:
            begin
                final_next  = byte_reg[7];
                opcode_next = byte_reg[3:0];
                cnt_next    = '0;
                phase_next  = PH_B1;
            end
        endcase

        if (len_known)
        begin
            if (known_masked)
            begin
                phase_next = PH_KEY;
                cnt_next   = KEY_BYTES;
            end
            else
            begin
                cnt_next = '0;
                hdr_done = 1'b1;
            end
        end

        if (hdr_done)
        begin
            idx_next = '0;
            grp_next = '0;
            if (known_len == 64'd0)
            begin
                frame_end = 1'b1;
            end
            else
            begin
                phase_next = PH_PAY;
            end
        end

        if (frame_end)
        begin
            if (final_reg && (opcode_reg == OP_CLOSE))
            begin
                evt_vld = 1'b1;
                evt     = '{kind: EV_CLOSE, x: 8'd0, y: 8'd0, color: 8'd0};
            end
            phase_next = PH_B0;
            cnt_next   = '0;
            idx_next   = '0;
            grp_next   = '0;
        end

        if (!step)
        begin
            evt_vld = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_B0;
            cnt_reg    <= '0;
            opcode_reg <= '0;
            final_reg  <= 1'b0;
            masked_reg <= 1'b0;
            len_reg    <= '0;
            idx_reg    <= '0;
            key_reg    <= '0;
            grp_reg    <= '0;
            held_x_reg <= '0;
            held_y_reg <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            opcode_reg <= opcode_next;
            final_reg  <= final_next;
            masked_reg <= masked_next;
            len_reg    <= len_next;
            idx_reg    <= idx_next;
            key_reg    <= key_next;
            grp_reg    <= grp_next;
            held_x_reg <= held_x_next;
            held_y_reg <= held_y_next;
        end
    end

    `ASSERT_PROP(a_no_event_in_b0, clk, rst_n, evt_vld |-> phase_reg != PH_B0)
    `ASSERT_PROP(a_pay_len_nonzero, clk, rst_n, (phase_reg == PH_PAY) |-> (len_reg != 64'd0))
    `ASSERT_PROP(a_pixel_third_byte, clk, rst_n, (evt_vld && evt.kind == EV_PIXEL) |-> (grp_reg == 2'd2))
    `ASSERT_NEVER(a_hdr_cnt_range, clk, rst_n, cnt_reg > EXT64_BYTES)

endmodule

@@ sv/wspfp_event_queue.sv @@
// ----------------------------------------------------------------------------
// Event queue
// Two-entry result buffer; decouples output stall from the parser.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wspfp_event_queue
    import wspfp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  event_t push_evt,
    output logic   full,
    output logic   out_vld,
    input  logic   out_stall,
    output event_t out_evt
);

    event_t     mem [2];
    logic [1:0] count_reg, count_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       pop;

    assign full    = (count_reg == 2'd2);
    assign out_vld = (count_reg != 2'd0);
    assign pop     = out_vld && !out_stall;
    assign out_evt = mem[rd_ptr_reg];

    always_comb
    begin
        count_next  = count_reg;
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        if (push)
        begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_evt;
        end
    end

    `ASSERT_NEVER(a_count_range, clk, rst_n, count_reg == 2'd3)
    `ASSERT_NEVER(a_push_when_full, clk, rst_n, push && full)
    `ASSERT_PROP(a_pop_drains, clk, rst_n, (pop && !push) |=> count_reg == $past(count_reg) - 2'd1)

endmodule

@@ sv/websocket_pixel_frame_parser_unit.sv @@
// Path: an accepted byte is held in the input register, decoded, and its event written into the event queue.
// Throughput: one byte per cycle while the queue is not full; the two-entry event queue absorbs output stall.
// in_stall rises only when the input register holds a byte and the queue is full.
// Reset (rst_n, async, active low) empties both stages and returns to the first header byte.
// ----------------------------------------------------------------------------
// WebSocket pixel frame parser
// Deframes a masked or unmasked WebSocket byte stream into pixel and close events.
// ----------------------------------------------------------------------------
module websocket_pixel_frame_parser_unit
    import wspfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       event_kind,
    output logic [7:0] pixel_x,
    output logic [7:0] pixel_y,
    output logic [7:0] pixel_color
);

    logic   q_full;
    logic   evt_vld;
    event_t evt;
    event_t out_evt;

    wspfp_frame_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_byte  (in_byte),
        .q_full   (q_full),
        .evt_vld  (evt_vld),
        .evt      (evt)
    );

    wspfp_event_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (evt_vld),
        .push_evt  (evt),
        .full      (q_full),
        .out_vld   (out_valid),
        .out_stall (out_stall),
        .out_evt   (out_evt)
    );

    assign event_kind  = out_evt.kind;
    assign pixel_x     = out_evt.x;
    assign pixel_y     = out_evt.y;
    assign pixel_color = out_evt.color;

endmodule

@@ tb/websocket_pixel_frame_parser_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// WebSocket pixel frame parser testbench
// Streams WebSocket frames into the parser one byte per transfer. Frames come
// from directed cases, random well-formed frames and random noise. A built-in
// frame decoder predicts each pixel and close event. A monitor compares every
// output transfer field by field. Random idling on both sides and a long
// output hold exercise the backpressure path.
// ----------------------------------------------------------------------------
module websocket_pixel_frame_parser_unit_tb;
    import wspfp_pkg::*;

    typedef enum logic [1:0] {
        LEN_SHORT,
        LEN_EXT16,
        LEN_EXT64
    } len_form_t;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 10;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       event_kind;
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
    logic [7:0] pixel_color;

    // decoder state
    phase_t      ph;
    logic [3:0]  hdr_left;
    logic [3:0]  opcode;
    logic        fin;
    logic        masked;
    logic [63:0] plen;
    logic [63:0] pidx;
    logic [31:0] key;
    logic [1:0]  grp;
    logic [7:0]  hx;
    logic [7:0]  hy;

    event_t pending_events[$];

    int  errors = 0;
    int  bytes_sent = 0;
    int  pixels_seen = 0;
    int  closes_seen = 0;
    int  idle_cycles = 0;
    int  hold_left = 0;
    int  recv_burst = 0;
    bit  send_idle = 1'b1;
    bit  recv_idle = 1'b1;

    websocket_pixel_frame_parser_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .event_kind  (event_kind),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_color (pixel_color)
    );

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    task automatic close_frame();
        if (fin && opcode == OP_CLOSE)
        begin
            pending_events.push_back('{kind: EV_CLOSE, x: 8'h00, y: 8'h00, color: 8'h00});
        end
        ph = PH_B0;
        hdr_left = 4'd0;
        pidx = 64'd0;
        grp = 2'd0;
    endtask

    task automatic start_payload();
        pidx = 64'd0;
        grp = 2'd0;
        if (plen == 64'd0)
        begin
            close_frame();
        end
        else
        begin
            ph = PH_PAY;
        end
    endtask

    task automatic length_known();
        if (masked)
        begin
            ph = PH_KEY;
            hdr_left = KEY_BYTES;
        end
        else
        begin
            hdr_left = 4'd0;
            start_payload();
        end
    endtask

    task automatic parse_byte(input logic [7:0] b);
        logic [7:0] v;
        case (ph)
            PH_B1:
            begin
                masked = b[7];
                key = 32'd0;
                if (b[6:0] == LEN7_EXT16)
                begin
                    plen = 64'd0;
                    hdr_left = EXT16_BYTES;
                    ph = PH_EXT;
                end
                else if (b[6:0] == LEN7_EXT64)
                begin
                    plen = 64'd0;
                    hdr_left = EXT64_BYTES;
                    ph = PH_EXT;
                end
                else
                begin
                    plen = {57'd0, b[6:0]};
                    length_known();
                end
            end
            PH_EXT:
            begin
                plen = {plen[55:0], b};
                if (hdr_left > 4'd0)
                    hdr_left = hdr_left - 4'd1;
                if (hdr_left == 4'd0)
                    length_known();
            end
            PH_KEY:
            begin
                key = {key[23:0], b};
                if (hdr_left > 4'd0)
                    hdr_left = hdr_left - 4'd1;
                if (hdr_left == 4'd0)
                    start_payload();
            end
            PH_PAY:
            begin
                v = b ^ key[8 * (3 - int'(pidx[1:0])) +: 8];
                if (grp == 2'd0)
                begin
                    hx = v;
                    grp = 2'd1;
                end
                else if (grp == 2'd1)
                begin
                    hy = v;
                    grp = 2'd2;
                end
                else
                begin
                    if (fin && opcode == OP_BINARY)
                    begin
                        pending_events.push_back('{kind: EV_PIXEL, x: hx, y: hy, color: v});
                    end
                    grp = 2'd0;
                end
                pidx = pidx + 64'd1;
                if (pidx >= plen)
                    close_frame();
            end
            default:
            begin
                fin = b[7];
                opcode = b[3:0];
                hdr_left = 4'd0;
                ph = PH_B1;
            end
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b);
        if (send_idle && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        do @(posedge clk); while (in_stall);
        parse_byte(b);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic f, input logic [3:0] op, input logic m,
                              input logic [31:0] k, input len_form_t form,
                              input logic [63:0] len, input int count, input int fill);
        send_byte({f, 3'($urandom_range(0, 7)), op});
        case (form)
            LEN_EXT16:
            begin
                send_byte({m, LEN7_EXT16});
                send_byte(len[15:8]);
                send_byte(len[7:0]);
            end
            LEN_EXT64:
            begin
                send_byte({m, LEN7_EXT64});
                for (int i = 7; i >= 0; i--)
                    send_byte(len[8 * i +: 8]);
            end
            default:
                send_byte({m, len[6:0]});
        endcase
        if (m)
        begin
            for (int i = 3; i >= 0; i--)
                send_byte(k[8 * i +: 8]);
        end
        for (int i = 0; i < count; i++)
            send_byte(fill < 0 ? 8'($urandom_range(0, 255)) : 8'(fill));
    endtask

    // random bytes, kept short enough that the stream realigns
    task automatic noise_burst();
        int n;
        logic [7:0] b;
        n = $urandom_range(1, 12);
        while (n > 0 || ph != PH_B0)
        begin
            b = 8'($urandom_range(0, 255));
            if (ph == PH_B1 && b[6:0] > 7'd40 && b[6:0] < LEN7_EXT16)
                b[6:0] = b[6:0] & 7'h1F;
            if (ph == PH_EXT && hdr_left > 4'd1)
                b = 8'h00;
            send_byte(b);
            if (n > 0)
                n--;
        end
    endtask

    task automatic random_frame();
        int pick;
        logic [3:0] op;
        logic f;
        logic m;
        logic [31:0] k;
        len_form_t form;
        logic [63:0] len;
        pick = $urandom_range(0, 19);
        if (pick == 19)
        begin
            noise_burst();
            return;
        end
        f = 1'b1;
        op = OP_BINARY;
        if (pick >= 12 && pick < 14)
            op = OP_CLOSE;
        else if (pick >= 14 && pick < 17)
            op = 4'($urandom_range(0, 15));
        else if (pick >= 17)
        begin
            f = 1'b0;
            op = 4'($urandom_range(0, 15));
        end
        m = ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 3))
            0: k = 32'h0000_0000;
            1: k = 32'hFFFF_FFFF;
            default: k = $urandom;
        endcase
        pick = $urandom_range(0, 19);
        if (pick < 16)
        begin
            form = LEN_SHORT;
            len = (pick < 14) ? 64'($urandom_range(0, 24)) : 64'($urandom_range(0, 125));
        end
        else if (pick < 18)
        begin
            form = LEN_EXT16;
            len = 64'($urandom_range(0, 200));
        end
        else
        begin
            form = LEN_EXT64;
            len = 64'($urandom_range(0, 40));
        end
        send_frame(f, op, m, k, form, len, int'(len), -1);
    endtask

    task automatic test_directed_frames();
        send_frame(1'b1, OP_CLOSE, 1'b0, 32'h0, LEN_SHORT, 64'd0, 0, -1);
        send_frame(1'b1, OP_BINARY, 1'b1, 32'hFFFF_FFFF, LEN_SHORT, 64'd4, 3, 0);
        send_byte(8'hFF);
        send_frame(1'b0, OP_BINARY, 1'b0, 32'h0, LEN_SHORT, 64'd3, 3, -1);
        send_frame(1'b1, 4'h1, 1'b0, 32'h0, LEN_SHORT, 64'd1, 1, 255);
        send_frame(1'b1, OP_CLOSE, 1'b1, 32'hA5C3_0F96, LEN_EXT16, 64'd2, 2, -1);
    endtask

    task automatic test_extended_lengths();
        send_frame(1'b1, OP_BINARY, 1'b1, 32'h1234_5678, LEN_EXT16, 64'd6, 6, -1);
        send_frame(1'b1, OP_BINARY, 1'b0, 32'h0, LEN_EXT64, 64'd7, 7, -1);
        send_frame(1'b1, OP_CLOSE, 1'b0, 32'h0, LEN_EXT64, 64'd0, 0, -1);
    endtask

    task automatic test_random_frames(input int target);
        while (bytes_sent < target)
            random_frame();
    endtask

    task automatic test_output_hold();
        send_idle = 1'b0;
        hold_left = 60;
        send_frame(1'b1, OP_BINARY, 1'b1, $urandom, LEN_SHORT, 64'd90, 90, -1);
        send_idle = 1'b1;
    endtask

    // length never runs out; the frame stays open to the end of the run
    task automatic test_huge_length();
        send_frame(1'b1, OP_BINARY, 1'b1, $urandom, LEN_EXT64, 64'hFFFF_FFFF_FFFF_FFFF, 45, -1);
    endtask

    // output side: random hold bursts plus a long forced hold
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (recv_burst > 0)
            begin
                out_stall <= 1'b1;
                recv_burst--;
            end
            else if (recv_idle && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                recv_burst = $urandom_range(1, 6) - 1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        event_t exp_ev;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_events.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected event: kind %0d x %02h y %02h color %02h",
                             event_kind, pixel_x, pixel_y, pixel_color);
            end
            else
            begin
                exp_ev = pending_events.pop_front();
                if (exp_ev.kind == EV_CLOSE)
                    closes_seen++;
                else
                    pixels_seen++;
                if (event_kind !== exp_ev.kind || pixel_x !== exp_ev.x
                    || pixel_y !== exp_ev.y || pixel_color !== exp_ev.color)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("event mismatch: expected %0d %02h %02h %02h, got %0d %02h %02h %02h",
                                 exp_ev.kind, exp_ev.x, exp_ev.y, exp_ev.color,
                                 event_kind, pixel_x, pixel_y, pixel_color);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        ph = PH_B0;
        hdr_left = 4'd0;
        opcode = 4'd0;
        fin = 1'b0;
        masked = 1'b0;
        plen = 64'd0;
        pidx = 64'd0;
        key = 32'd0;
        grp = 2'd0;
        hx = 8'd0;
        hy = 8'd0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_frames();
        test_extended_lengths();
        test_random_frames(420);
        test_output_hold();
        send_idle = 1'b0;
        recv_idle = 1'b0;
        test_random_frames(650);
        test_huge_length();

        in_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d stream bytes; checked %0d pixel and %0d close events,",
                 bytes_sent, pixels_seen, closes_seen);
        $display("with random idling, a long output hold and an open 64-bit length frame.");
        if (errors == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("%0d errors", errors);
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
